[hdl/simrank_pairwise_iteration_core_macros.svh]
// Assertion macros for the SimRank core sequencer.
`ifndef SIMRANK_PAIRWISE_ITERATION_CORE_MACROS_SVH
`define SIMRANK_PAIRWISE_ITERATION_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/spi_pkg.sv]
// Types and constants shared by the SimRank core modules.
`timescale 1ns / 1ps
package spi_pkg;
   localparam int VTX_BITS  = 6;
   localparam int NUM_VTX   = 64;
   localparam int ADDR_BITS = 12;
   localparam int NUM_CELLS = 4096;
   localparam int SCORE_W   = 16;
   localparam int PART_W    = 22;
   localparam int ACC_W     = 28;
   localparam int DEG_W     = 7;
   localparam int DEN_W     = 13;
   localparam int DECAY_W   = 16;
   localparam int PROD_W    = 44;
   localparam int CNT_W     = 7;
   localparam int SWEEP_W   = 8;

   localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

   // Request commands.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_DECAY  = 2'd0;
   localparam logic [1:0] REG_SWEEPS = 2'd1;
   localparam logic [1:0] REG_VCOUNT = 2'd2;

   // Accumulator sources.
   localparam logic [1:0] ACC_NONE  = 2'd0;
   localparam logic [1:0] ACC_ADJ   = 2'd1;
   localparam logic [1:0] ACC_SCORE = 2'd2;
   localparam logic [1:0] ACC_PART  = 2'd3;

   // Score write sources.
   localparam logic [1:0] WSEL_ZERO = 2'd0;
   localparam logic [1:0] WSEL_ONE  = 2'd1;
   localparam logic [1:0] WSEL_QUOT = 2'd2;

   typedef struct packed {
      logic                 adj_we;
      logic                 adj_wd;
      logic [ADDR_BITS-1:0] adj_waddr;
      logic [ADDR_BITS-1:0] adj_raddr;
      logic                 score_we;
      logic [1:0]           score_wsel;
      logic [ADDR_BITS-1:0] score_waddr;
      logic [ADDR_BITS-1:0] score_raddr;
      logic                 part_we;
      logic [ADDR_BITS-1:0] part_waddr;
      logic [ADDR_BITS-1:0] part_raddr;
      logic                 deg_we;
      logic [VTX_BITS-1:0]  deg_waddr;
      logic [VTX_BITS-1:0]  deg_raddr0;
      logic [VTX_BITS-1:0]  deg_raddr1;
      logic                 acc_clr;
      logic [1:0]           acc_src;
      logic                 mul_ld;
      logic                 div_start;
   } dp_cmd_type;

   typedef struct packed {
      logic               deg_zero;
      logic               div_done;
      logic [SCORE_W-1:0] score_q;
   } dp_status_type;
endpackage

[hdl/spi_if.sv]
// Request and response channel interfaces of the SimRank core.
`timescale 1ns / 1ps
interface spi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [5:0] first_vertex;
   logic [5:0] second_vertex;
   modport source (output valid, command, first_vertex, second_vertex, input ready);
   modport sink (input valid, command, first_vertex, second_vertex, output ready);
endinterface

interface spi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] score;
   logic        bad_vertex;
   modport source (output valid, score, bad_vertex, input ready);
   modport sink (input valid, score, bad_vertex, output ready);
endinterface

[hdl/simrank_pairwise_iteration_core.sv]
// Top level of the SimRank core: register port, channels, sequencer and datapath.
// Add edge and rejected requests: result in the cycle after the transfer; read: through the read state.
// Clear: one store entry per cycle over all 4096 entries.
// Run: its length is set by the one-term-per-cycle degree count and, in every sweep, accumulate loops
// over the vertices in use, and by the 28-step divide for each off-diagonal score with nonzero degrees.
// Reset clears control state and starts a clearing pass over all 4096 entries; no request is taken meanwhile.
`timescale 1ns / 1ps
module simrank_pairwise_iteration_core
   import spi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   spi_req_if.sink       req_chan,
   spi_rsp_if.source     rsp_chan,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_write_data
);
   logic [DECAY_W-1:0] decay_ff;
   logic [SWEEP_W-1:0] sweeps_ff;
   logic [CNT_W-1:0]   vcount_ff;
   logic [CNT_W-1:0]   vtx_used;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= 16'd39322;
         sweeps_ff <= 8'd50;
         vcount_ff <= 7'd64;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DECAY:  decay_ff  <= csr_write_data;
            REG_SWEEPS: sweeps_ff <= csr_write_data[7:0];
            REG_VCOUNT: vcount_ff <= csr_write_data[6:0];
            default:    ;
         endcase
      end
   end

   // Vertex counts above the built size act as the built size.
   assign vtx_used = (vcount_ff > 7'(NUM_VTX)) ? 7'(NUM_VTX) : vcount_ff;

   spi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .req_first   (req_chan.first_vertex),
      .req_second  (req_chan.second_vertex),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_score   (rsp_chan.score),
      .rsp_bad     (rsp_chan.bad_vertex),
      .vtx_used    (vtx_used),
      .sweeps      (sweeps_ff),
      .status      (status),
      .cmd         (cmd)
   );

   spi_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .decay  (decay_ff),
      .cmd    (cmd),
      .status (status)
   );
endmodule

[hdl/spi_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module spi_divider
   import spi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [ACC_W-1:0] quotient,
   output logic             done
);
   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] div_ff;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   // One shift-and-subtract step.
   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], quo_ff[ACC_W-1]};
      fits    = rem_sh >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'(ACC_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ACC_W-2:0], fits};
         rem_in = fits ? rem_sh - {1'b0, div_ff} : rem_sh;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Step registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         div_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

[hdl/spi_datapath.sv]
// Score, partial-sum, adjacency and degree stores with the accumulate, multiply and divide path.
`timescale 1ns / 1ps
module spi_datapath
   import spi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [DECAY_W-1:0] decay,
   input  dp_cmd_type         cmd,
   output dp_status_type      status
);
   logic               adj_mem   [NUM_CELLS];
   logic [SCORE_W-1:0] score_mem [NUM_CELLS];
   logic [PART_W-1:0]  part_mem  [NUM_CELLS];
   logic [DEG_W-1:0]   deg_mem   [NUM_VTX];

   logic               adj_q_ff;
   logic [SCORE_W-1:0] score_q_ff;
   logic [PART_W-1:0]  part_q_ff;
   logic [DEG_W-1:0]   deg0_q_ff, deg1_q_ff;
   logic [1:0]         src_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in, term;
   logic [PROD_W-1:0]  prod_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [SCORE_W-1:0] score_wd;
   logic [ACC_W-1:0]   quotient;
   logic               div_done;

   // Score write data.
   always_comb begin
      case (cmd.score_wsel)
         WSEL_ONE:  score_wd = SCORE_ONE;
         WSEL_QUOT: score_wd = quotient[SCORE_W-1:0];
         default:   score_wd = '0;
      endcase
   end

   // Stores with registered reads.
   always_ff @(posedge clock) begin
      if (cmd.adj_we) begin
         adj_mem[cmd.adj_waddr] <= cmd.adj_wd;
      end
      adj_q_ff <= adj_mem[cmd.adj_raddr];
      if (cmd.score_we) begin
         score_mem[cmd.score_waddr] <= score_wd;
      end
      score_q_ff <= score_mem[cmd.score_raddr];
      if (cmd.part_we) begin
         part_mem[cmd.part_waddr] <= acc_ff[PART_W-1:0];
      end
      part_q_ff <= part_mem[cmd.part_raddr];
      if (cmd.deg_we) begin
         deg_mem[cmd.deg_waddr] <= acc_ff[DEG_W-1:0];
      end
      deg0_q_ff <= deg_mem[cmd.deg_raddr0];
      deg1_q_ff <= deg_mem[cmd.deg_raddr1];
   end

   // Term selected by the source that issued the read in the previous cycle.
   always_comb begin
      case (src_ff)
         ACC_ADJ:   term = ACC_W'(adj_q_ff);
         ACC_SCORE: term = adj_q_ff ? ACC_W'(score_q_ff) : '0;
         ACC_PART:  term = adj_q_ff ? ACC_W'(part_q_ff) : '0;
         default:   term = '0;
      endcase
      acc_in = cmd.acc_clr ? '0 : acc_ff + term;
   end

   // Accumulator, product and denominator.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.mul_ld) begin
         prod_ff <= PROD_W'(decay) * PROD_W'(acc_ff);
         den_ff  <= DEN_W'(deg0_q_ff) * DEN_W'(deg1_q_ff);
      end
      if (reset) begin
         src_ff <= ACC_NONE;
      end else begin
         src_ff <= cmd.acc_src;
      end
   end

   spi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff[PROD_W-1:16]),
      .divisor  (den_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.deg_zero = (deg0_q_ff == '0) || (deg1_q_ff == '0);
   assign status.div_done = div_done;
   assign status.score_q  = score_q_ff;
endmodule

[hdl/spi_ctrl.sv]
// Command sequencer: request handling, clearing pass, degree count and sweep loops.
`timescale 1ns / 1ps
module spi_ctrl
   import spi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [VTX_BITS-1:0] req_first,
   input  logic [VTX_BITS-1:0] req_second,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SCORE_W-1:0] rsp_score,
   output logic               rsp_bad,
   input  logic [CNT_W-1:0]   vtx_used,
   input  logic [SWEEP_W-1:0] sweeps,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);
   `include "simrank_pairwise_iteration_core_macros.svh"

   localparam logic [4:0] ST_CLEAR    = 5'd0;
   localparam logic [4:0] ST_IDLE     = 5'd1;
   localparam logic [4:0] ST_READ     = 5'd2;
   localparam logic [4:0] ST_DEG_RD   = 5'd3;
   localparam logic [4:0] ST_DEG_WAIT = 5'd4;
   localparam logic [4:0] ST_DEG_WR   = 5'd5;
   localparam logic [4:0] ST_A_RD     = 5'd6;
   localparam logic [4:0] ST_A_WAIT   = 5'd7;
   localparam logic [4:0] ST_A_WR     = 5'd8;
   localparam logic [4:0] ST_B_PAIR   = 5'd9;
   localparam logic [4:0] ST_B_RD     = 5'd10;
   localparam logic [4:0] ST_B_WAIT   = 5'd11;
   localparam logic [4:0] ST_B_MUL    = 5'd12;
   localparam logic [4:0] ST_B_DIVS   = 5'd13;
   localparam logic [4:0] ST_B_DIVW   = 5'd14;
   localparam logic [4:0] ST_B_WR     = 5'd15;

   logic [4:0]           state_ff, state_in;
   logic [VTX_BITS-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [SWEEP_W-1:0]   sweep_ff, sweep_in;
   logic [1:0]           wsel_ff, wsel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;
   logic                 rsp_bad_ff, rsp_bad_in;
   logic                 last_x, last_y, last_z, fire, bad;

   assign last_x    = {1'b0, x_ff} == vtx_used - 7'd1;
   assign last_y    = {1'b0, y_ff} == vtx_used - 7'd1;
   assign last_z    = {1'b0, z_ff} == vtx_used - 7'd1;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign fire      = req_valid && req_ready;
   assign bad       = ({1'b0, req_first} >= vtx_used) || ({1'b0, req_second} >= vtx_used);

   // Next state, loop counters, response and datapath commands.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      sweep_in     = sweep_ff;
      wsel_in      = wsel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_score_in = rsp_score_ff;
      rsp_bad_in   = rsp_bad_ff;
      cmd            = '0;
      cmd.deg_raddr0 = x_ff;
      cmd.deg_raddr1 = y_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.adj_we      = 1'b1;
            cmd.adj_waddr   = clr_ff;
            cmd.score_we    = 1'b1;
            cmd.score_waddr = clr_ff;
            cmd.score_wsel  = (clr_ff[11:6] == clr_ff[5:0]) ? WSEL_ONE : WSEL_ZERO;
            clr_in          = clr_ff + 12'd1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_score_in = '0;
                  rsp_bad_in   = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            cmd.score_raddr = {req_first, req_second};
            if (fire) begin
               rsp_score_in = '0;
               rsp_bad_in   = 1'b0;
               unique case (req_command)
                  CMD_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  CMD_RUN: begin
                     if (vtx_used == '0 || sweeps == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        x_in     = '0;
                        z_in     = '0;
                        state_in = ST_DEG_RD;
                     end
                  end
                  CMD_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_bad_in    = bad;
                     cmd.adj_we    = !bad;
                     cmd.adj_wd    = 1'b1;
                     cmd.adj_waddr = {req_first, req_second};
                  end
                  default: begin
                     if (bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_bad_in   = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_score_in = status.score_q;
            rsp_bad_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_DEG_RD: begin
            cmd.adj_raddr = {z_ff, x_ff};
            cmd.acc_src   = ACC_ADJ;
            cmd.acc_clr   = z_ff == '0;
            z_in          = z_ff + 6'd1;
            if (last_z) begin
               state_in = ST_DEG_WAIT;
            end
         end
         ST_DEG_WAIT: begin
            state_in = ST_DEG_WR;
         end
         ST_DEG_WR: begin
            cmd.deg_we    = 1'b1;
            cmd.deg_waddr = x_ff;
            z_in          = '0;
            state_in      = ST_DEG_RD;
            x_in          = x_ff + 6'd1;
            if (last_x) begin
               x_in     = '0;
               y_in     = '0;
               sweep_in = '0;
               state_in = ST_A_RD;
            end
         end
         ST_A_RD: begin
            cmd.adj_raddr   = {z_ff, y_ff};
            cmd.score_raddr = {x_ff, z_ff};
            cmd.acc_src     = ACC_SCORE;
            cmd.acc_clr     = z_ff == '0;
            z_in            = z_ff + 6'd1;
            if (last_z) begin
               state_in = ST_A_WAIT;
            end
         end
         ST_A_WAIT: begin
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            cmd.part_we    = 1'b1;
            cmd.part_waddr = {x_ff, y_ff};
            z_in           = '0;
            state_in       = ST_A_RD;
            y_in           = y_ff + 6'd1;
            if (last_y) begin
               y_in = '0;
               x_in = x_ff + 6'd1;
               if (last_x) begin
                  x_in     = '0;
                  state_in = ST_B_PAIR;
               end
            end
         end
         ST_B_PAIR: begin
            z_in = '0;
            if (x_ff == y_ff) begin
               wsel_in  = WSEL_ONE;
               state_in = ST_B_WR;
            end else begin
               state_in = ST_B_RD;
            end
         end
         ST_B_RD: begin
            cmd.adj_raddr  = {z_ff, x_ff};
            cmd.part_raddr = {z_ff, y_ff};
            cmd.acc_src    = ACC_PART;
            cmd.acc_clr    = z_ff == '0;
            z_in           = z_ff + 6'd1;
            if (last_z) begin
               state_in = ST_B_WAIT;
            end
         end
         ST_B_WAIT: begin
            state_in = ST_B_MUL;
         end
         ST_B_MUL: begin
            if (status.deg_zero) begin
               wsel_in  = WSEL_ZERO;
               state_in = ST_B_WR;
            end else begin
               cmd.mul_ld = 1'b1;
               state_in   = ST_B_DIVS;
            end
         end
         ST_B_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_B_DIVW;
         end
         ST_B_DIVW: begin
            if (status.div_done) begin
               wsel_in  = WSEL_QUOT;
               state_in = ST_B_WR;
            end
         end
         ST_B_WR: begin
            cmd.score_we    = 1'b1;
            cmd.score_waddr = {x_ff, y_ff};
            cmd.score_wsel  = wsel_ff;
            state_in        = ST_B_PAIR;
            y_in            = y_ff + 6'd1;
            if (last_y) begin
               y_in = '0;
               x_in = x_ff + 6'd1;
               if (last_x) begin
                  // One sweep finished.
                  x_in     = '0;
                  sweep_in = sweep_ff + 8'd1;
                  state_in = ST_A_RD;
                  if (sweep_ff + 8'd1 == sweeps) begin
                     rsp_valid_in = 1'b1;
                     rsp_score_in = '0;
                     rsp_bad_in   = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and response registers.
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      sweep_ff     <= sweep_in;
      wsel_ff      <= wsel_in;
      rsp_score_ff <= rsp_score_in;
      rsp_bad_ff   <= rsp_bad_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_bad   = rsp_bad_ff;

   `SPI_ASSERT_NOW(a_no_overwrite, clock, reset, fire, !rsp_valid_ff || rsp_ready, "accepted while a result waits")
   `SPI_ASSERT_NOW(a_sweep_in_range, clock, reset, state_ff == ST_B_WR, ({1'b0, x_ff} < vtx_used) && ({1'b0, y_ff} < vtx_used), "sweep write outside the vertices in use")
   `SPI_ASSERT_NEXT(a_div_to_write, clock, reset, state_ff == ST_B_DIVW && status.div_done, state_ff == ST_B_WR && wsel_ff == WSEL_QUOT, "quotient not written after divide")
   `SPI_ASSERT_NEXT(a_clear_ends_idle, clock, reset, state_ff == ST_CLEAR && clr_ff == '1, state_ff == ST_IDLE, "clearing pass did not end")
endmodule

[tb/sv/spi_checker.sv]
// Checker for the SimRank core: it watches both channels and the register port, predicts and compares.
`timescale 1ns / 1ps
module spi_checker
   import spi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spi_req_if          req_mon,
   spi_rsp_if          rsp_mon,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          fail_count
);
   typedef struct packed {
      logic [15:0] score;
      logic        bad_vertex;
   } score_reply_type;

   // Predicted graph, scores and register copies.
   logic [15:0]  decay_q;
   logic [7:0]   sweeps_q;
   logic [6:0]   vcount_q;
   bit           edge_bit [NUM_VTX][NUM_VTX];
   logic [15:0]  sim [NUM_VTX][NUM_VTX];
   score_reply_type expected_replies [$];

   function automatic int active_vertices();
      return (vcount_q > NUM_VTX) ? NUM_VTX : int'(vcount_q);
   endfunction

   function automatic void wipe_graph();
      for (int a = 0; a < NUM_VTX; a++)
         for (int b = 0; b < NUM_VTX; b++) begin
            edge_bit[a][b] = 0;
            sim[a][b] = (a == b) ? SCORE_ONE : 16'd0;
         end
   endfunction

   // Performs the configured number of sweeps; each reads only the prior sweep.
   function automatic void simrank_sweeps();
      int          n;
      int          deg [NUM_VTX];
      longint      part [NUM_VTX][NUM_VTX];
      logic [15:0] fresh [NUM_VTX][NUM_VTX];
      longint      acc;
      n = active_vertices();
      for (int v = 0; v < n; v++) begin
         deg[v] = 0;
         for (int a = 0; a < n; a++)
            deg[v] += edge_bit[a][v];
      end
      for (int k = 0; k < sweeps_q; k++) begin
         for (int a = 0; a < n; a++)
            for (int j = 0; j < n; j++) begin
               acc = 0;
               for (int b = 0; b < n; b++)
                  if (edge_bit[b][j]) acc += sim[a][b];
               part[a][j] = acc;
            end
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               if (i == j) fresh[i][j] = SCORE_ONE;
               else if (deg[i] == 0 || deg[j] == 0) fresh[i][j] = 16'd0;
               else begin
                  acc = 0;
                  for (int a = 0; a < n; a++)
                     if (edge_bit[a][i]) acc += part[a][j];
                  fresh[i][j] = 16'((longint'(decay_q) * acc) /
                                    ((longint'(deg[i]) * deg[j]) << 16));
               end
            end
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
               sim[i][j] = fresh[i][j];
      end
   endfunction

   function automatic score_reply_type apply_request(logic [1:0] cmd, int u, int v);
      score_reply_type r;
      int n;
      r = '0;
      n = active_vertices();
      if (cmd == CMD_CLEAR) wipe_graph();
      else if (cmd == CMD_RUN) simrank_sweeps();
      else if (u >= n || v >= n) r.bad_vertex = 1'b1;
      else if (cmd == CMD_ADD) edge_bit[u][v] = 1;
      else r.score = sim[u][v];
      return r;
   endfunction

   initial begin
      fail_count = 0;
      decay_q = 16'd39322;
      sweeps_q = 8'd50;
      vcount_q = 7'd64;
      wipe_graph();
   end

   // Register writes, request prediction and response comparison.
   always @(posedge clock) begin
      score_reply_type want;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_DECAY:  decay_q <= csr_write_data;
               REG_SWEEPS: sweeps_q <= csr_write_data[7:0];
               REG_VCOUNT: vcount_q <= csr_write_data[6:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_replies.push_back(apply_request(req_mon.command,
               int'(req_mon.first_vertex), int'(req_mon.second_vertex)));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_replies.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_mon.score !== want.score) begin
                  $error("score mismatch: expected %0d, actual %0d", want.score, rsp_mon.score);
                  fail_count++;
               end
               if (rsp_mon.bad_vertex !== want.bad_vertex) begin
                  $error("bad_vertex mismatch: expected %0d, actual %0d",
                         want.bad_vertex, rsp_mon.bad_vertex);
                  fail_count++;
               end
            end
         end
      end
   end

   // Expectations still waiting at the end; the top fails the run if any remain.
   function automatic int leftover();
      return expected_replies.size();
   endfunction
endmodule

[tb/sv/tb.sv]
// Testbench top for the SimRank core: stimulus, response pacing and the verdict.
`timescale 1ns / 1ps
module tb
   import spi_pkg::*;
;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int EDGE_CAP    = 200;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;
   int          fail_count;
   int          sent_count;
   int          reply_count;
   int          cycle_count;
   bit          quiet;
   int          stall_left;

   spi_req_if req_chan ();
   spi_rsp_if rsp_chan ();

   simrank_pairwise_iteration_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   spi_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Cycle limit and response counting.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) reply_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // The response side stalls in short random bursts until the quiet stretch.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // One request transfer, with an occasional idle gap in front of it.
   task automatic put_req(logic [1:0] cmd, logic [5:0] u, logic [5:0] v);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.first_vertex <= u;
      req_chan.second_vertex <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // Waits until every response has arrived, then lets the core settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (reply_count != sent_count) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] dec, logic [7:0] sweeps, logic [6:0] vcount);
      write_reg(REG_DECAY, dec);
      write_reg(REG_SWEEPS, 16'(sweeps));
      write_reg(REG_VCOUNT, 16'(vcount));
   endtask

   // One phase: clear, edges with rejects, run, reads and edges, maybe a rerun.
   task automatic graph_phase(int n, int reads);
      int edges;
      put_req(CMD_CLEAR, 6'($urandom), 6'($urandom));
      edges = $urandom_range(n, (n * n + 2 > EDGE_CAP) ? EDGE_CAP : n * n + 2);
      for (int e = 0; e < edges; e++) begin
         if ($urandom_range(0, 9) == 0) put_req(CMD_ADD, 6'($urandom), 6'($urandom));
         else put_req(CMD_ADD, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
      end
      put_req(CMD_RUN, 6'($urandom), 6'($urandom));
      for (int r = 0; r < reads; r++) begin
         case ($urandom_range(0, 9))
            0: put_req(CMD_READ, 6'($urandom), 6'($urandom));
            1: put_req(CMD_ADD, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
            2: put_req(CMD_ADD, 6'($urandom), 6'($urandom));
            default:
               put_req(CMD_READ, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
         endcase
      end
      if ($urandom_range(0, 1) == 1) begin
         put_req(CMD_RUN, 6'($urandom), 6'($urandom));
         for (int r = 0; r < 10; r++)
            put_req(CMD_READ, 6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
      end
   endtask

   initial begin
      int n;
      logic [15:0] dec;
      reset = 1'b1;
      quiet = 1'b0;
      sent_count = 0;
      reply_count = 0;
      cycle_count = 0;
      req_chan.valid <= 1'b0;
      req_chan.command <= CMD_CLEAR;
      req_chan.first_vertex <= '0;
      req_chan.second_vertex <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= REG_DECAY;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: duplicates, self loop, rejects, largest decay and sweep count.
      set_regs(16'hFFFF, 8'd255, 7'd2);
      put_req(CMD_ADD, 6'd0, 6'd1);
      put_req(CMD_ADD, 6'd1, 6'd0);
      put_req(CMD_ADD, 6'd0, 6'd1);
      put_req(CMD_ADD, 6'd1, 6'd1);
      put_req(CMD_ADD, 6'd63, 6'd0);
      put_req(CMD_ADD, 6'd0, 6'd63);
      put_req(CMD_RUN, 6'd63, 6'd63);
      put_req(CMD_READ, 6'd0, 6'd1);
      put_req(CMD_READ, 6'd1, 6'd0);
      put_req(CMD_READ, 6'd1, 6'd1);
      put_req(CMD_READ, 6'd63, 6'd63);
      drain();
      // A vertex count of zero rejects everything and a run does nothing.
      write_reg(REG_VCOUNT, 16'd0);
      put_req(CMD_ADD, 6'd0, 6'd0);
      put_req(CMD_READ, 6'd0, 6'd1);
      put_req(CMD_RUN, 6'd0, 6'd0);
      drain();
      // A count above the built size acts as the full size; leave edges up high.
      write_reg(REG_VCOUNT, 16'd127);
      put_req(CMD_ADD, 6'd63, 6'd63);
      put_req(CMD_ADD, 6'd2, 6'd40);
      put_req(CMD_ADD, 6'd40, 6'd2);
      put_req(CMD_READ, 6'd63, 6'd62);
      drain();
      // Edges beyond the count are ignored by a run; zero decay, one sweep.
      set_regs(16'd0, 8'd1, 7'd4);
      put_req(CMD_ADD, 6'd0, 6'd2);
      put_req(CMD_ADD, 6'd3, 6'd2);
      put_req(CMD_RUN, 6'd0, 6'd0);
      put_req(CMD_READ, 6'd1, 6'd2);
      drain();
      write_reg(REG_VCOUNT, 16'd64);
      put_req(CMD_READ, 6'd40, 6'd2);
      put_req(CMD_READ, 6'd0, 6'd0);
      drain();
      // Full size with no sweeps: a run answers at once and changes no score.
      write_reg(REG_SWEEPS, 16'd0);
      graph_phase(64, 40);
      drain();

      // Random phases on small graphs; the last ones without idling.
      for (int p = 0; p < 16; p++) begin
         if (p >= 13) quiet = 1'b1;
         n = $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0: dec = 16'hFFFF;
            1: dec = 16'd0;
            default: dec = 16'($urandom);
         endcase
         if (p == 5) set_regs(dec, 8'd255, 7'd2);
         else set_regs(dec, 8'($urandom_range(0, 5)), 7'(n));
         graph_phase((p == 5) ? 2 : n, 90);
         drain();
      end

      if (fail_count == 0 && u_checker.leftover() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
